// ===== hw/rtl/npw_pkg.sv =====
// npw_pkg: shared widths, codes, state type and structs for the nearest path point block
// no dependencies; imported by every module in hw/rtl
package npw_pkg;

  localparam int PATH_DEPTH = 4096;
  localparam int MAX_WINDOW = 32;

  localparam int K_W        = 17;
  localparam int OFF_W      = 6;
  localparam int COORD_W    = 24;
  localparam int SPEED_W    = 16;
  localparam int IDX_W      = 12;
  localparam int STEP_W     = 5;
  localparam int SQ_W       = 49;
  localparam int DIST_W     = 50;
  localparam int COURSE_W   = 13;
  localparam int WIN_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 88;

  localparam logic [CFG_IDX_W-1:0] CFG_COURSE_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 2'd1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [COURSE_W-1:0] COURSE_LEN_RST = 13'd1;
  localparam logic [WIN_W-1:0]    WINDOW_LEN_RST = 6'd30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LOAD,
    ST_EMIT
  } npw_state_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } path_pt_t;

  typedef struct packed {
    logic              vld;
    logic              busy;
    logic [OFF_W-1:0]  off;
    logic [DIST_W-1:0] sqd;
  } dist_res_t;

endpackage

// ===== hw/rtl/npw_path_mem.sv =====
// npw_path_mem: waypoint store, one write port and one read port with registered read data
// depends on npw_pkg
module npw_path_mem import npw_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  path_pt_t      wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output path_pt_t      rd_data
);

  path_pt_t mem [DEPTH];
  path_pt_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/npw_dist.sv =====
// npw_dist: three stage squared distance pipeline (difference, squares, sum)
// depends on npw_pkg
module npw_dist import npw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [OFF_W-1:0]   in_off,
  input  logic [COORD_W-1:0] veh_x,
  input  logic [COORD_W-1:0] veh_y,
  input  logic [COORD_W-1:0] pt_x,
  input  logic [COORD_W-1:0] pt_y,
  output dist_res_t          res
);

  logic                       v1_r, v2_r, v3_r;
  logic [OFF_W-1:0]           o1_r, o2_r, o3_r;
  logic signed [COORD_W:0]    dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [2*COORD_W+1:0] prod_x, prod_y;
  logic [SQ_W-1:0]            sqx_r, sqy_r;
  logic [DIST_W-1:0]          d_r, d_nxt;

  assign dx_nxt = $signed({veh_x[COORD_W-1], veh_x}) - $signed({pt_x[COORD_W-1], pt_x});
  assign dy_nxt = $signed({veh_y[COORD_W-1], veh_y}) - $signed({pt_y[COORD_W-1], pt_y});
  assign prod_x = dx_r * dx_r;
  assign prod_y = dy_r * dy_r;
  assign d_nxt  = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    o1_r  <= in_off;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    o2_r  <= o1_r;
    sqx_r <= prod_x[SQ_W-1:0];
    sqy_r <= prod_y[SQ_W-1:0];
    o3_r  <= o2_r;
    d_r   <= d_nxt;
  end

  assign res.vld  = v3_r;
  assign res.busy = v1_r | v2_r | v3_r;
  assign res.off  = o3_r;
  assign res.sqd  = d_r;

endmodule

// ===== hw/rtl/nearest_path_point_reference_window.sv =====
// nearest_path_point_reference_window: path store, nearest waypoint search, reference horizon
// depends on npw_pkg, npw_path_mem, npw_dist
//
//   channel  dir  handshake             contents
//   in_      in   in_tvalid/in_tready   waypoint write or position query
//   out_     out  out_tvalid/out_tready one reference point, tlast on final step
//   cfg_     in   cfg_valid/cfg_ready   course_len (index 0), window_len (index 1)
//
// a write request completes in the idle state; a query runs a search over up to w
// waypoints (fewer when the path ends inside the window), a first read and w output
// points, w being the effective window length; search and output share the single path
// memory read port, so one request is in flight at a time
// output stalls hold the read data in the memory output register; no clearing pass after reset
module nearest_path_point_reference_window import npw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // point_index, point_x, point_y, point_speed, vehicle_x, vehicle_y, prev_index
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // nearest_index, step, ref_x, ref_y, ref_speed, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(PATH_DEPTH);
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam logic [K_W-1:0] DEPTH_K  = K_W'(PATH_DEPTH);
  localparam logic [7:0]     MAXWIN_8 = 8'(MAX_WINDOW);

  npw_state_t state_r, state_nxt;

  logic [COURSE_W-1:0] course_len_r, course_len_nxt;
  logic [WIN_W-1:0]    window_len_r, window_len_nxt;
  logic [COORD_W-1:0]  vx_r, vx_nxt, vy_r, vy_nxt;
  logic [IDX_W-1:0]    pind_r, pind_nxt;
  logic [K_W-1:0]      clen_r, clen_nxt;
  logic [WW-1:0]       w_r, w_nxt;
  logic [WW-1:0]       iss_r, iss_nxt;
  logic                v0_r, v0_nxt;
  logic [OFF_W-1:0]    o0_r, o0_nxt;
  logic [DIST_W-1:0]   best_r, best_nxt;
  logic [OFF_W-1:0]    boff_r, boff_nxt;
  logic [K_W-1:0]      ind_r, ind_nxt;
  logic [WW-1:0]       st_r, st_nxt;

  logic           in_fire, out_fire, cfg_fire, last;
  logic [K_W-1:0] clen_eff, course_k, k_iss, k_emit, emit_k;
  logic [WW-1:0]  w_eff, st_sel;
  logic [7:0]     win_8, st_8;
  logic           issue, rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [K_W-1:0] wr_idx;
  path_pt_t       wr_pt, rd_pt;
  dist_res_t      dres;

  // in_tdata fields
  logic [IDX_W-1:0]   f_point_index, f_prev_index;
  logic [COORD_W-1:0] f_point_x, f_point_y, f_vehicle_x, f_vehicle_y;
  logic [SPEED_W-1:0] f_point_speed;

  assign f_point_index = in_tdata[11:0];
  assign f_point_x     = in_tdata[35:12];
  assign f_point_y     = in_tdata[59:36];
  assign f_point_speed = in_tdata[75:60];
  assign f_vehicle_x   = in_tdata[99:76];
  assign f_vehicle_y   = in_tdata[123:100];
  assign f_prev_index  = in_tdata[135:124];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign cfg_ready  = 1'b1;
  assign in_fire    = in_tvalid & in_tready;
  assign out_fire   = out_tvalid & out_tready;
  assign cfg_fire   = cfg_valid & cfg_ready;

  // effective register values
  assign course_k = K_W'(course_len_r);
  assign win_8    = 8'(window_len_r);
  always_comb begin
    if (course_k == '0) begin
      clen_eff = K_W'(1);
    end else if (course_k > DEPTH_K) begin
      clen_eff = DEPTH_K;
    end else begin
      clen_eff = course_k;
    end
    if (win_8 == '0) begin
      w_eff = WW'(1);
    end else if (win_8 > MAXWIN_8) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(window_len_r);
    end
  end

  // search read addresses
  assign k_iss = K_W'(pind_r) + K_W'(iss_r);
  assign issue = (state_r == ST_SEARCH) && (iss_r < w_r) && (k_iss < clen_r);

  // horizon read addresses, clamped at the path end
  assign last   = (st_r == w_r - WW'(1));
  assign st_sel = (state_r == ST_LOAD) ? '0 : st_r + WW'(1);
  assign k_emit = ind_r + K_W'(st_sel);
  assign emit_k = (k_emit >= clen_r) ? clen_r - K_W'(1) : k_emit;

  assign rd_en   = issue | (state_r == ST_LOAD) | (out_fire & ~last);
  assign rd_addr = (state_r == ST_SEARCH) ? k_iss[AW-1:0] : emit_k[AW-1:0];

  // waypoint writes
  assign wr_idx   = K_W'(f_point_index);
  assign wr_en    = in_fire && (in_tuser == FUNC_WRITE) && (wr_idx < DEPTH_K);
  assign wr_addr  = wr_idx[AW-1:0];
  assign wr_pt.x  = f_point_x;
  assign wr_pt.y  = f_point_y;
  assign wr_pt.speed = f_point_speed;

  npw_path_mem #(
    .DEPTH (PATH_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_pt),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_pt)
  );

  npw_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (v0_r),
    .in_off (o0_r),
    .veh_x  (vx_r),
    .veh_y  (vy_r),
    .pt_x   (rd_pt.x),
    .pt_y   (rd_pt.y),
    .res    (dres)
  );

  always_comb begin
    state_nxt      = state_r;
    course_len_nxt = course_len_r;
    window_len_nxt = window_len_r;
    vx_nxt   = vx_r;
    vy_nxt   = vy_r;
    pind_nxt = pind_r;
    clen_nxt = clen_r;
    w_nxt    = w_r;
    iss_nxt  = iss_r;
    v0_nxt   = 1'b0;
    o0_nxt   = OFF_W'(iss_r);
    best_nxt = best_r;
    boff_nxt = boff_r;
    ind_nxt  = ind_r;
    st_nxt   = st_r;

    if (cfg_fire) begin
      case (cfg_index)
        CFG_COURSE_LEN: course_len_nxt = cfg_data;
        CFG_WINDOW_LEN: window_len_nxt = cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser == FUNC_QUERY)) begin
          vx_nxt    = f_vehicle_x;
          vy_nxt    = f_vehicle_y;
          pind_nxt  = f_prev_index;
          clen_nxt  = clen_eff;
          w_nxt     = w_eff;
          iss_nxt   = '0;
          best_nxt  = '1;
          boff_nxt  = '0;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        v0_nxt = issue;
        if (issue) begin
          iss_nxt = iss_r + WW'(1);
        end
        if (dres.vld && (dres.sqd < best_r)) begin
          best_nxt = dres.sqd;
          boff_nxt = dres.off;
        end
        if (!issue && !v0_r && !dres.busy) begin
          ind_nxt   = K_W'(pind_r) + K_W'(boff_r);
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        st_nxt    = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            st_nxt = st_r + WW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      course_len_r <= COURSE_LEN_RST;
      window_len_r <= WINDOW_LEN_RST;
      v0_r         <= 1'b0;
      iss_r        <= '0;
      st_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      course_len_r <= course_len_nxt;
      window_len_r <= window_len_nxt;
      v0_r         <= v0_nxt;
      iss_r        <= iss_nxt;
      st_r         <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    pind_r <= pind_nxt;
    clen_r <= clen_nxt;
    w_r    <= w_nxt;
    o0_r   <= o0_nxt;
    best_r <= best_nxt;
    boff_r <= boff_nxt;
    ind_r  <= ind_nxt;
  end

  assign st_8      = 8'(st_r);
  assign out_tlast = last;
  assign out_tdata = {7'b0, rd_pt.speed, rd_pt.y, rd_pt.x, st_8[STEP_W-1:0],
                      ind_r[IDX_W-1:0]};

`ifndef SYNTH
  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_tlast) |=> in_tready)
    else $error("block not idle after final reference point");

  a_best_never_rises: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |=> (best_r <= $past(best_r)))
    else $error("running minimum increased during search");

  a_step_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_tlast) |=> (out_tvalid && (st_r == $past(st_r) + WW'(1))))
    else $error("horizon step did not advance by one");

  a_nearest_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (ind_r >= K_W'(pind_r)))
    else $error("nearest index before window start");
`endif

endmodule
